### sv/bvs_pkg.sv
// ----------------------------------------------------------------------------
// bvs_pkg
// Types and constants shared by the bit vector store and its parts.
// ----------------------------------------------------------------------------
package bvs_pkg;

    // field widths
    localparam int OPCODE_W = 3;
    localparam int INDEX_W  = 10;
    localparam int LENGTH_W = 11;
    localparam int CAP_W    = 11;

    // capacity register after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_SET    = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_GET    = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd4;

    // status codes
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    // input beat
    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [INDEX_W-1:0]  index;
        logic                bit_value;
    } t_in_item;

    // output beat
    typedef struct packed {
        logic                status;
        logic                read_bit;
        logic [LENGTH_W-1:0] current_length;
    } t_out_item;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SHIFT,
        ST_RESP
    } t_state;

endpackage

### sv/bvs_ram.sv
// ----------------------------------------------------------------------------
// bvs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bvs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/bit_vector_store_top.sv
// ----------------------------------------------------------------------------
// bit_vector_store_top
// Variable-length bit vector in a 1-bit RAM with a length count and a
// capacity register. Append, set, get, remove and clear, one result each.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+----------------------
//   in       | in        | i_in_valid / o_in_ready | i_in_data  (t_in_item)
//   out      | out       | o_out_valid/i_out_ready | o_out_data (t_out_item)
//   cfg      | in        | i_cfg_we (no wait)      | i_cfg_data (capacity)
//
// Append, set, get, clear and failing ops are accepted (RAM read issued),
// then executed with the result loaded into the output register.
// Remove is accepted, executed, then shifts each later bit down one place:
// one RAM read and one delayed write per later bit, plus a final drain step.
// Synchronous active-low reset clears length and handshake state, loads CAP_RESET.
// A result that finds the output register full waits and stalls the input.
// ----------------------------------------------------------------------------
module bit_vector_store_top
    import bvs_pkg::*;
#(
    parameter int MAX_BITS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data
);

    localparam int AW   = $clog2(MAX_BITS);
    localparam int LW   = $clog2(MAX_BITS + 1);
    localparam int CMPW = (LW > LENGTH_W) ? LW : LENGTH_W;
    localparam logic [CMPW-1:0] MAX_C = CMPW'(MAX_BITS);

    // state and registers
    t_state              r_state, n_state;
    logic [LW-1:0]       r_len, n_len;
    logic [CAP_W-1:0]    r_cap;
    logic [OPCODE_W-1:0] r_op;
    logic [INDEX_W-1:0]  r_idx;
    logic                r_val;
    logic [LW-1:0]       r_ptr, n_ptr;
    logic                r_wr_pend, n_wr_pend;
    logic [AW-1:0]       r_wr_addr, n_wr_addr;
    t_out_item           r_res, n_res;
    t_out_item           r_out;
    logic                r_out_valid;

    // RAM controls
    logic          w_we, w_re;
    logic [AW-1:0] w_waddr, w_raddr;
    logic          w_wdata, w_rdata;

    // decode
    logic            w_accept, w_slot_free;
    logic [CMPW-1:0] w_len_ext, w_idx_ext, w_cap_ext, w_in_idx_ext, w_ptr_ext;
    logic [LW-1:0]   w_ptr_dec;
    logic            w_idx_ok, w_app_ok, w_go_shift, w_ptr_in, w_shift_done, w_fin;

    assign o_in_ready   = (r_state == ST_IDLE);
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_slot_free  = !r_out_valid || i_out_ready;

    assign w_len_ext    = CMPW'(r_len);
    assign w_idx_ext    = CMPW'(r_idx);
    assign w_cap_ext    = CMPW'(r_cap);
    assign w_in_idx_ext = CMPW'(i_in_data.index);
    assign w_ptr_ext    = w_idx_ext + CMPW'(1);
    assign w_ptr_dec    = r_ptr - LW'(1);

    assign w_idx_ok     = (w_idx_ext < w_len_ext) && (w_idx_ext < MAX_C);
    assign w_app_ok     = (w_len_ext < w_cap_ext) && (w_len_ext < MAX_C);
    assign w_go_shift   = (r_op == OP_REMOVE) && w_idx_ok;
    assign w_ptr_in     = (r_ptr < r_len);
    assign w_shift_done = !w_ptr_in && !r_wr_pend;
    assign w_fin        = ((r_state == ST_EXEC) && !w_go_shift) ||
                          ((r_state == ST_SHIFT) && w_shift_done);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_go_shift) begin
                    n_state = ST_SHIFT;
                end else begin
                    n_state = w_slot_free ? ST_IDLE : ST_RESP;
                end
            end
            ST_SHIFT: begin
                if (w_shift_done) begin
                    n_state = w_slot_free ? ST_IDLE : ST_RESP;
                end
            end
            ST_RESP: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // datapath and RAM controls
    always_comb begin
        w_we      = 1'b0;
        w_re      = 1'b0;
        w_waddr   = r_wr_addr;
        w_wdata   = w_rdata;
        w_raddr   = w_in_idx_ext[AW-1:0];
        n_len     = r_len;
        n_ptr     = r_ptr;
        n_wr_pend = 1'b0;
        n_wr_addr = r_wr_addr;
        n_res     = r_res;
        case (r_state)
            ST_IDLE: begin
                // early read for get
                w_re = w_accept;
            end
            ST_EXEC: begin
                n_res.status   = ST_ERR;
                n_res.read_bit = 1'b0;
                n_ptr          = w_ptr_ext[LW-1:0];
                case (r_op)
                    OP_APPEND: begin
                        if (w_app_ok) begin
                            w_we           = 1'b1;
                            w_waddr        = w_len_ext[AW-1:0];
                            w_wdata        = r_val;
                            n_len          = r_len + LW'(1);
                            n_res.status   = ST_OK;
                        end
                    end
                    OP_SET: begin
                        if (w_idx_ok) begin
                            w_we           = 1'b1;
                            w_waddr        = w_idx_ext[AW-1:0];
                            w_wdata        = r_val;
                            n_res.status   = ST_OK;
                        end
                    end
                    OP_GET: begin
                        if (w_idx_ok) begin
                            n_res.read_bit = w_rdata;
                            n_res.status   = ST_OK;
                        end
                    end
                    OP_REMOVE: begin
                        // handled by the shift loop when in range
                    end
                    OP_CLEAR: begin
                        n_len          = '0;
                        n_res.status   = ST_OK;
                    end
                    default: begin
                    end
                endcase
            end
            ST_SHIFT: begin
                // read bit at ptr, write it one place down next cycle
                w_re      = w_ptr_in;
                w_raddr   = r_ptr[AW-1:0];
                w_we      = r_wr_pend;
                w_waddr   = r_wr_addr;
                w_wdata   = w_rdata;
                n_wr_pend = w_ptr_in;
                n_wr_addr = w_ptr_dec[AW-1:0];
                n_ptr     = r_ptr + LW'(1);
                if (w_shift_done) begin
                    n_len          = r_len - LW'(1);
                    n_res.status   = ST_OK;
                    n_res.read_bit = 1'b0;
                end
            end
            ST_RESP: begin
            end
            default: begin
            end
        endcase
        n_res.current_length = LENGTH_W'(n_len);
    end

    // bit store
    bvs_ram #(
        .WIDTH(1),
        .DEPTH(MAX_BITS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_cap       <= CAP_RESET;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_wr_pend <= n_wr_pend;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if ((w_fin || (r_state == ST_RESP)) && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_in_data.opcode;
            r_idx <= i_in_data.index;
            r_val <= i_in_data.bit_value;
        end
        r_ptr     <= n_ptr;
        r_wr_addr <= n_wr_addr;
        if (w_fin) begin
            r_res <= n_res;
        end
        if (w_fin && w_slot_free) begin
            r_out <= n_res;
        end else if ((r_state == ST_RESP) && w_slot_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
